// ===== src/ltaq_pkg.sv =====
`default_nettype none
package ltaq_pkg;

  typedef enum logic [1:0] {
    SP_NONE,
    SP_ZERO,
    SP_ONE,
    SP_HALF
  } spec_t;

  typedef enum logic [1:0] {
    REG_SIDE_LEN,
    REG_LEVELS_FIRST,
    REG_LEVELS_SECOND,
    REG_NONE
  } reg_idx_t;

  localparam int IN_W   = 9;
  localparam int DIFF_W = 10;
  localparam int PROD_W = 22;
  localparam int CFG_AW = 4;
  localparam int LVL_W  = 10;
  localparam int SIZE_W = 9;

  // atan(2^-i) in quarter turns, 32 fractional bits
  localparam logic [31:0] ATAN_TAB [33] = '{
    32'd2147483648, 32'd1267733622, 32'd669835629, 32'd340019024, 32'd170669324,
    32'd85417861, 32'd42719353, 32'd21360980, 32'd10680653, 32'd5340347,
    32'd2670176, 32'd1335088, 32'd667544, 32'd333772, 32'd166886,
    32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215,
    32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5,
    32'd3, 32'd1, 32'd1
  };

  function automatic logic [63:0] atan_round(input int i, input int f);
    int          sh;
    logic [63:0] t;
    sh = 32 - f;
    t  = {32'd0, ATAN_TAB[i]};
    if (sh > 0) begin
      t = (t + (64'd1 << (sh - 1))) >> sh;
    end
    return t;
  endfunction

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  function automatic logic [PROD_W-1:0] abs_prod(input logic signed [PROD_W-1:0] v);
    return v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
  endfunction

endpackage
`default_nettype wire

// ===== src/lattice_triangle_angle_quantizer_top.sv =====
// channel | group | tdata / tuser contents
// in      | in_   | tdata: first_dx, first_dy, second_dx, second_dy (9b each)
// out     | out_  | tdata: first_angle_bin, second_angle_bin; tuser: accepted
// cfg     | cfg_  | APB, side_len @0, angle_levels_first @4, angle_levels_second @8
// A 25-stage CORDIC at the default; one word per cycle while the output is not stalled.
// The CORDIC iteration count min(ANGLE_FRAC_BITS+1,33) sets the depth.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; in_tready follows it.
`default_nettype none
module lattice_triangle_angle_quantizer_top
  import ltaq_pkg::*;
#(
  parameter int MAX_SIZE        = 256,
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output      logic              in_tready,
  // first_dx, first_dy, second_dx, second_dy, pad
  input  wire logic [39:0]       in_tdata,
  output      logic              out_tvalid,
  input  wire logic              out_tready,
  // first_angle_bin, second_angle_bin, pad
  output      logic [23:0]       out_tdata,
  // accepted
  output      logic              out_tuser,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output      logic [31:0]       cfg_prdata,
  output      logic              cfg_pready
);

  localparam int F    = ANGLE_FRAC_BITS;
  localparam int N    = (F + 1 > 33) ? 33 : F + 1;
  localparam int XW   = PROD_W + 33;
  localparam int ZW   = F + 3;
  localparam int SZW0 = $clog2(MAX_SIZE + 1);
  localparam int SZW  = (SZW0 > 11) ? SZW0 : 11;
  localparam int QW   = F + 1 + LVL_W + 1;

  // configuration
  logic [SIZE_W-1:0] side_len_r;
  logic [LVL_W-1:0]  lvl1_r, lvl2_r;
  reg_idx_t          cfg_idx;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_len_r <= SIZE_W'(16);
      lvl1_r     <= LVL_W'(8);
      lvl2_r     <= LVL_W'(8);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SIDE_LEN:      side_len_r <= cfg_pwdata[SIZE_W-1:0];
        REG_LEVELS_FIRST:  lvl1_r     <= cfg_pwdata[LVL_W-1:0];
        REG_LEVELS_SECOND: lvl2_r     <= cfg_pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SIDE_LEN:      cfg_prdata = 32'(side_len_r);
      REG_LEVELS_FIRST:  cfg_prdata = 32'(lvl1_r);
      REG_LEVELS_SECOND: cfg_prdata = 32'(lvl2_r);
      default:           cfg_prdata = 32'd0;
    endcase
  end

  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // stage 1: input register
  logic                     v1_r;
  logic signed [IN_W-1:0]   ax_r, ay_r, bx_r, by_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= in_tdata[8:0];
      ay_r <= in_tdata[17:9];
      bx_r <= in_tdata[26:18];
      by_r <= in_tdata[35:27];
    end
  end

  // stage 2: products and bounds
  logic signed [DIFF_W-1:0] ax_e, ay_e, bx_e, by_e, ux, uy;
  logic [SZW-1:0]           sz_sat, img_e;
  logic                     inb;

  assign ax_e = DIFF_W'(ax_r);
  assign ay_e = DIFF_W'(ay_r);
  assign bx_e = DIFF_W'(bx_r);
  assign by_e = DIFF_W'(by_r);
  assign ux   = bx_e - ax_e;
  assign uy   = by_e - ay_e;
  assign img_e  = SZW'(side_len_r);
  assign sz_sat = (img_e > SZW'(MAX_SIZE)) ? SZW'(MAX_SIZE) : img_e;
  assign inb = (SZW'(abs_diff(ax_e)) < sz_sat) && (SZW'(abs_diff(ay_e)) < sz_sat) &&
               (SZW'(abs_diff(bx_e)) < sz_sat) && (SZW'(abs_diff(by_e)) < sz_sat) &&
               (SZW'(abs_diff(ux)) < sz_sat)   && (SZW'(abs_diff(uy)) < sz_sat);

  logic                     v2_r, inb_r;
  logic signed [PROD_W-1:0] dot_r, crs_r, l1_r, l2_r, l3_r, dot2_r, crs2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inb_r  <= inb;
      dot_r  <= PROD_W'(ax_e * bx_e) + PROD_W'(ay_e * by_e);
      crs_r  <= PROD_W'(ay_e * bx_e) - PROD_W'(ax_e * by_e);
      l1_r   <= PROD_W'(ax_e * ax_e) + PROD_W'(ay_e * ay_e);
      l2_r   <= PROD_W'(bx_e * bx_e) + PROD_W'(by_e * by_e);
      l3_r   <= PROD_W'(ux * ux) + PROD_W'(uy * uy);
      dot2_r <= -(PROD_W'(ux * ax_e) + PROD_W'(uy * ay_e));
      crs2_r <= PROD_W'(uy * ax_e) - PROD_W'(ux * ay_e);
    end
  end

  // stage 3: acceptance, special angles, CORDIC seed
  logic                     ok;
  logic [PROD_W-1:0]        ac1, ac2;
  spec_t                    sp1, sp2;

  assign ok  = inb_r && !dot_r[PROD_W-1] && (dot_r <= l1_r) && !crs_r[PROD_W-1] &&
               (l1_r != '0) && (l2_r != '0) && (l3_r != '0);
  assign ac1 = abs_prod(crs_r);
  assign ac2 = abs_prod(crs2_r);

  always_comb begin
    priority if (ac1 == '0)               sp1 = SP_ZERO;
    else if (dot_r == '0)                 sp1 = SP_ONE;
    else if (PROD_W'(dot_r) == ac1)       sp1 = SP_HALF;
    else                                  sp1 = SP_NONE;
    priority if (ac2 == '0)               sp2 = SP_ZERO;
    else if (dot2_r == '0)                sp2 = SP_ONE;
    else if (PROD_W'(dot2_r) == ac2)      sp2 = SP_HALF;
    else                                  sp2 = SP_NONE;
  end

  logic                 cv_r  [N+1];
  logic                 cok_r [N+1];
  spec_t                csp_r [2][N+1];
  logic signed [XW-1:0] x_r   [2][N+1];
  logic signed [XW-1:0] y_r   [2][N+1];
  logic signed [ZW-1:0] z_r   [2][N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) cv_r[k] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= v2_r;
      for (int k = 1; k <= N; k++) cv_r[k] <= cv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cok_r[0]    <= ok;
      csp_r[0][0] <= sp1;
      csp_r[1][0] <= sp2;
      x_r[0][0]   <= $signed({(XW-32)'(dot_r), 32'd0});
      y_r[0][0]   <= $signed({(XW-32)'(ac1), 32'd0});
      x_r[1][0]   <= $signed({(XW-32)'(dot2_r), 32'd0});
      y_r[1][0]   <= $signed({(XW-32)'(ac2), 32'd0});
      z_r[0][0]   <= '0;
      z_r[1][0]   <= '0;
      for (int k = 1; k <= N; k++) begin
        cok_r[k]    <= cok_r[k-1];
        csp_r[0][k] <= csp_r[0][k-1];
        csp_r[1][k] <= csp_r[1][k-1];
      end
    end
  end

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    for (genvar i = 0; i < N; i++) begin : g_it
      localparam logic signed [ZW-1:0] AZ = ZW'(atan_round(i, F));
      logic signed [XW-1:0] dx, dy;
      assign dx = y_r[ln][i] >>> i;
      assign dy = x_r[ln][i] >>> i;
      always_ff @(posedge clk) begin
        if (en) begin
          if (!y_r[ln][i][XW-1]) begin
            x_r[ln][i+1] <= x_r[ln][i] + dx;
            y_r[ln][i+1] <= y_r[ln][i] - dy;
            z_r[ln][i+1] <= z_r[ln][i] + AZ;
          end else begin
            x_r[ln][i+1] <= x_r[ln][i] - dx;
            y_r[ln][i+1] <= y_r[ln][i] + dy;
            z_r[ln][i+1] <= z_r[ln][i] - AZ;
          end
        end
      end
    end
  end

  // clamp and special override
  logic [F:0] zc [2];
  always_comb begin
    for (int ln = 0; ln < 2; ln++) begin
      unique case (csp_r[ln][N])
        SP_ZERO: zc[ln] = '0;
        SP_ONE:  zc[ln] = (F+1)'(1) << F;
        SP_HALF: zc[ln] = (F+1)'(1) << (F - 1);
        default: begin
          priority if (z_r[ln][N][ZW-1])                  zc[ln] = '0;
          else if (z_r[ln][N] > ZW'(1) <<< F)             zc[ln] = (F+1)'(1) << F;
          else                                            zc[ln] = z_r[ln][N][F:0];
        end
      endcase
    end
  end

  logic       vz_r, okz_r;
  logic [F:0] zf_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) vz_r <= 1'b0;
    else if (en) vz_r <= cv_r[N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      okz_r   <= cok_r[N];
      zf_r[0] <= zc[0];
      zf_r[1] <= zc[1];
    end
  end

  // quantize into the output register
  logic [QW-1:0] q1, q2;
  assign q1 = QW'(zf_r[0]) * QW'(lvl1_r) + (QW'(1) << (F - 1));
  assign q2 = QW'(zf_r[1]) * QW'(lvl2_r) + (QW'(1) << (F - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= vz_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tuser <= okz_r;
      out_tdata <= okz_r ? {4'd0, q2[F+9:F], q1[F+9:F]} : 24'd0;
    end
  end

endmodule
`default_nettype wire

// ===== src/ltaq_checker.sv =====
`default_nettype none
module ltaq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled word changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");

  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 24'd0)
    else $error("rejected pair with nonzero bins");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid after reset");

endmodule

bind lattice_triangle_angle_quantizer_top ltaq_checker u_ltaq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
